// ===== design/amo_pkg.sv =====
package amo_pkg;

  localparam int unsigned MaxCentersDef = 8;
  localparam int unsigned QuantumMaxDef = 65535;
  localparam int unsigned FracBitsDef   = 4;

  localparam int unsigned ChanW   = 16;
  localparam int unsigned CoordW  = 20;
  localparam int unsigned CfgW    = 20;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned RadSqW  = 2 * CoordW;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_PIXEL  = 2'd2
  } amo_cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_FILL   = 3'd2,
    REG_OUTER  = 3'd3,
    REG_INNER  = 3'd4,
    REG_KEEP   = 3'd5
  } amo_reg_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [CoordW-1:0] center_x;
    logic [CoordW-1:0] center_y;
    logic [ChanW-1:0]  pixel_x;
    logic [ChanW-1:0]  pixel_y;
    logic [ChanW-1:0]  src_red;
    logic [ChanW-1:0]  src_green;
    logic [ChanW-1:0]  src_blue;
  } amo_in_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic             hole_too_big;
  } amo_out_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } amo_rgb_t;

  // stage load enables shared by all lanes
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } amo_pipe_en_t;

endpackage

// ===== design/amo_table.sv =====
module amo_table import amo_pkg::*; #(
  parameter int unsigned MAX_CENTERS = MaxCentersDef,
  parameter int unsigned FRAC_BITS   = FracBitsDef,
  parameter int unsigned CW          = CoordW
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_i,
  input  logic [1:0]                      cmd_i,
  input  logic [CoordW-1:0]               center_x_i,
  input  logic [CoordW-1:0]               center_y_i,
  input  logic [ChanW-1:0]                image_width_i,
  input  logic [ChanW-1:0]                image_height_i,
  output logic [MAX_CENTERS-1:0][CW-1:0]  cx_o,
  output logic [MAX_CENTERS-1:0][CW-1:0]  cy_o,
  output logic [MAX_CENTERS-1:0]          lane_en_o
);

  localparam int unsigned CntW = $clog2(MAX_CENTERS + 1);

  logic [CoordW-1:0] tab_x_q [MAX_CENTERS];
  logic [CoordW-1:0] tab_y_q [MAX_CENTERS];
  logic [CntW-1:0]   cnt_d, cnt_q;
  logic              do_clear, do_append;

  assign do_clear  = wr_i && (amo_cmd_e'(cmd_i) == CMD_CLEAR);
  assign do_append = wr_i && (amo_cmd_e'(cmd_i) == CMD_APPEND) &&
                     (cnt_q < CntW'(MAX_CENTERS));

  always_comb begin
    cnt_d = cnt_q;
    if (do_clear) begin
      cnt_d = '0;
    end else if (do_append) begin
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_CENTERS; i++) begin
      if (do_append && (cnt_q == CntW'(i))) begin
        tab_x_q[i] <= center_x_i;
        tab_y_q[i] <= center_y_i;
      end
    end
  end

  // empty table: lane 0 tests the image midpoint
  always_comb begin
    for (int i = 0; i < MAX_CENTERS; i++) begin
      cx_o[i]      = CW'(tab_x_q[i]);
      cy_o[i]      = CW'(tab_y_q[i]);
      lane_en_o[i] = cnt_q > CntW'(i);
    end
    if (cnt_q == '0) begin
      cx_o[0]      = CW'(image_width_i) << (FRAC_BITS - 1);
      cy_o[0]      = CW'(image_height_i) << (FRAC_BITS - 1);
      lane_en_o[0] = 1'b1;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_CENTERS))
    else $error("center count past limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_clear |=> cnt_q == '0)
    else $error("clear did not empty the table");

endmodule

// ===== design/amo_lane.sv =====
module amo_lane import amo_pkg::*; #(
  parameter int unsigned CW = CoordW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  amo_pipe_en_t      en_i,
  input  logic [CW-1:0]     px_i,
  input  logic [CW-1:0]     py_i,
  input  logic [CW-1:0]     cx_i,
  input  logic [CW-1:0]     cy_i,
  input  logic              lane_en_i,
  input  logic [RadSqW-1:0] r2_i,
  input  logic [RadSqW-1:0] h2_i,
  output logic              hit_o
);

  localparam int unsigned SqW  = 2 * CW;
  localparam int unsigned SumW = SqW + 1;

  logic [CW-1:0]   ax_d, ay_d, ax_q, ay_q;
  logic [SqW-1:0]  sqx_q, sqy_q;
  logic [SumW-1:0] dsq;
  logic            en1_q, en2_q, hit_q;

  assign ax_d = (px_i >= cx_i) ? px_i - cx_i : cx_i - px_i;
  assign ay_d = (py_i >= cy_i) ? py_i - cy_i : cy_i - py_i;
  assign dsq  = SumW'(sqx_q) + SumW'(sqy_q);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      ax_q  <= ax_d;
      ay_q  <= ay_d;
      en1_q <= lane_en_i;
    end
    if (en_i.s2) begin
      sqx_q <= ax_q * ax_q;
      sqy_q <= ay_q * ay_q;
      en2_q <= en1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (en_i.s3) begin
      hit_q <= en2_q && (dsq >= SumW'(h2_i)) && (dsq <= SumW'(r2_i));
    end
  end

  assign hit_o = hit_q;

endmodule

// ===== design/annulus_mask_overlay.sv =====
// Annulus mask overlay: paints disks or rings onto a stream of pixels.
// Input channel (in_valid_i / in_stall_o / in_item_i) carries three kinds
// of item: clear the center table, append a center (dropped once the table
// holds MAX_CENTERS), or a pixel. Only pixel items produce a result on the
// output channel (out_valid_o / out_stall_i / out_item_o).
// Each pixel is tested against every stored center in parallel lanes; an
// empty table means the image midpoint. Pipeline: abs difference, square,
// sum and range compare, color select into the output register.
// A pixel's result passes the lane stage registers in order and shows when
// out_valid_o rises; one item per cycle is accepted until every stage is
// full under a receiver stall. Squared radii are registered from the radii.
// Configuration goes through cfg_we_i / cfg_idx_i / cfg_data_i while the
// block is idle; the user is bound to that, the block does not enforce it.
// Reset clears the center table count, all valid bits and the registers
// to their defaults. When the receiver stalls, each stage holds while the
// stage after it is full; bubbles are squeezed out, and in_stall_o rises
// only when every stage is occupied.
module annulus_mask_overlay import amo_pkg::*; #(
  parameter int unsigned MAX_CENTERS = MaxCentersDef,
  parameter int unsigned QUANTUM_MAX = QuantumMaxDef,
  parameter int unsigned FRAC_BITS   = FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  amo_in_t            in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output amo_out_t           out_item_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  localparam int unsigned PW = ChanW + FRAC_BITS;
  localparam int unsigned CW = (PW > CoordW) ? PW : CoordW;

  logic [ChanW-1:0]  width_q, height_q, fill_q;
  logic [CoordW-1:0] outer_q, inner_q;
  logic              keep_q;
  logic [RadSqW-1:0] r2_q, h2_q;
  logic              too_big_q;

  logic              accept;
  logic              ready1, ready2, ready3, ready4;
  logic              v1_q, v2_q, v3_q, vout_q;
  amo_pipe_en_t      pen;
  amo_rgb_t          rgb1_q, rgb2_q, rgb3_q;
  amo_out_t          out_d, out_q;

  logic [MAX_CENTERS-1:0][CW-1:0] cx, cy;
  logic [MAX_CENTERS-1:0]         lane_en, hit;
  logic [CW-1:0]                  px, py;
  logic                           paint;
  logic [ChanW:0]                 bg_diff;
  logic [ChanW-1:0]               bg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ChanW'(1);
      height_q <= ChanW'(1);
      fill_q   <= ChanW'(65535);
      outer_q  <= CoordW'(1600);
      inner_q  <= '0;
      keep_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (amo_reg_e'(cfg_idx_i))
        REG_WIDTH:  width_q  <= cfg_data_i[ChanW-1:0];
        REG_HEIGHT: height_q <= cfg_data_i[ChanW-1:0];
        REG_FILL:   fill_q   <= cfg_data_i[ChanW-1:0];
        REG_OUTER:  outer_q  <= cfg_data_i[CoordW-1:0];
        REG_INNER:  inner_q  <= cfg_data_i[CoordW-1:0];
        REG_KEEP:   keep_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    r2_q      <= outer_q * outer_q;
    h2_q      <= inner_q * inner_q;
    too_big_q <= inner_q > outer_q;
  end

  // stage handshake
  assign ready4 = !vout_q || !out_stall_i;
  assign ready3 = !v3_q || ready4;
  assign ready2 = !v2_q || ready3;
  assign ready1 = !v1_q || ready2;

  assign in_stall_o = !ready1;
  assign accept     = in_valid_i && ready1;
  assign pen        = '{s1: ready1, s2: ready2, s3: ready3};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      vout_q <= 1'b0;
    end else begin
      if (ready1) v1_q <= accept && (amo_cmd_e'(in_item_i.cmd) == CMD_PIXEL);
      if (ready2) v2_q <= v1_q;
      if (ready3) v3_q <= v2_q;
      if (ready4) vout_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready1) begin
      rgb1_q <= '{red: in_item_i.src_red, green: in_item_i.src_green,
                  blue: in_item_i.src_blue};
    end
    if (ready2) rgb2_q <= rgb1_q;
    if (ready3) rgb3_q <= rgb2_q;
    if (ready4) out_q  <= out_d;
  end

  amo_table #(
    .MAX_CENTERS (MAX_CENTERS),
    .FRAC_BITS   (FRAC_BITS),
    .CW          (CW)
  ) u_table (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_i           (accept),
    .cmd_i          (in_item_i.cmd),
    .center_x_i     (in_item_i.center_x),
    .center_y_i     (in_item_i.center_y),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .cx_o           (cx),
    .cy_o           (cy),
    .lane_en_o      (lane_en)
  );

  assign px = CW'(in_item_i.pixel_x) << FRAC_BITS;
  assign py = CW'(in_item_i.pixel_y) << FRAC_BITS;

  for (genvar g = 0; g < MAX_CENTERS; g++) begin : g_lane
    amo_lane #(
      .CW (CW)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (pen),
      .px_i      (px),
      .py_i      (py),
      .cx_i      (cx[g]),
      .cy_i      (cy[g]),
      .lane_en_i (lane_en[g]),
      .r2_i      (r2_q),
      .h2_i      (h2_q),
      .hit_o     (hit[g])
    );
  end

  assign bg_diff = (ChanW+1)'(QUANTUM_MAX) - {1'b0, fill_q};
  assign bg      = ({1'b0, fill_q} > (ChanW+1)'(QUANTUM_MAX)) ? '0 : bg_diff[ChanW-1:0];
  assign paint   = (|hit) && !too_big_q;

  always_comb begin
    out_d.hole_too_big = too_big_q;
    if (paint) begin
      out_d.out_red   = fill_q;
      out_d.out_green = fill_q;
      out_d.out_blue  = fill_q;
    end else if (keep_q) begin
      out_d.out_red   = rgb3_q.red;
      out_d.out_green = rgb3_q.green;
      out_d.out_blue  = rgb3_q.blue;
    end else begin
      out_d.out_red   = bg;
      out_d.out_green = bg;
      out_d.out_blue  = bg;
    end
  end

  assign out_valid_o = vout_q;
  assign out_item_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && vout_q && out_stall_i))
    else $error("input stalled with a free stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(v3_q))
    else $error("result without an item in the last stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.hole_too_big && !keep_q) |->
      (out_item_o.out_red == bg && out_item_o.out_blue == bg))
    else $error("painted pixel with hole larger than disk");

endmodule

// ===== dv/annulus_mask_overlay_tb.sv =====
`timescale 1ns / 100ps

import amo_pkg::*;

typedef longint unsigned u64_t;

class annulus_predictor;
  logic [ChanW-1:0]  img_w, img_h, fill;
  logic [CoordW-1:0] r_out, r_in;
  logic              keep;
  logic [CoordW-1:0] tab_x [MaxCentersDef];
  logic [CoordW-1:0] tab_y [MaxCentersDef];
  int unsigned       n_centers;
  amo_out_t          expected_pixels [$];
  int                mismatches;

  function new();
    img_w      = 1;
    img_h      = 1;
    fill       = 16'hFFFF;
    r_out      = 1600;
    r_in       = 0;
    keep       = 1'b1;
    n_centers  = 0;
    mismatches = 0;
  endfunction

  function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    case (idx)
      REG_WIDTH:  img_w = data[ChanW-1:0];
      REG_HEIGHT: img_h = data[ChanW-1:0];
      REG_FILL:   fill  = data[ChanW-1:0];
      REG_OUTER:  r_out = data[CoordW-1:0];
      REG_INNER:  r_in  = data[CoordW-1:0];
      REG_KEEP:   keep  = data[0];
      default: ;
    endcase
  endfunction

  function u64_t dist2(logic [CoordW-1:0] ax, logic [CoordW-1:0] ay,
                       logic [CoordW-1:0] bx, logic [CoordW-1:0] by);
    longint dx, dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return u64_t'(dx * dx + dy * dy);
  endfunction

  function void take_item(amo_in_t it);
    amo_out_t          res;
    u64_t              r2, h2, d;
    logic [CoordW-1:0] px, py;
    logic              hit;
    logic [ChanW-1:0]  bg;
    case (it.cmd)
      CMD_CLEAR: n_centers = 0;
      CMD_APPEND: begin
        if (n_centers < MaxCentersDef) begin
          tab_x[n_centers] = it.center_x;
          tab_y[n_centers] = it.center_y;
          n_centers++;
        end
      end
      CMD_PIXEL: begin
        px = CoordW'(it.pixel_x) << FracBitsDef;
        py = CoordW'(it.pixel_y) << FracBitsDef;
        r2 = u64_t'(r_out) * u64_t'(r_out);
        h2 = u64_t'(r_in) * u64_t'(r_in);
        res.hole_too_big = r_in > r_out;
        hit = 1'b0;
        if (!res.hole_too_big) begin
          if (n_centers == 0) begin
            d = dist2(px, py, CoordW'(img_w) << (FracBitsDef - 1),
                      CoordW'(img_h) << (FracBitsDef - 1));
            hit = d >= h2 && d <= r2;
          end else begin
            for (int i = 0; i < n_centers; i++) begin
              d = dist2(px, py, tab_x[i], tab_y[i]);
              if (d >= h2 && d <= r2) hit = 1'b1;
            end
          end
        end
        bg = (fill > QuantumMaxDef) ? '0 : ChanW'(QuantumMaxDef - fill);
        if (hit) begin
          res.out_red   = fill;
          res.out_green = fill;
          res.out_blue  = fill;
        end else if (keep) begin
          res.out_red   = it.src_red;
          res.out_green = it.src_green;
          res.out_blue  = it.src_blue;
        end else begin
          res.out_red   = bg;
          res.out_green = bg;
          res.out_blue  = bg;
        end
        expected_pixels = {expected_pixels, res};
      end
      default: ;
    endcase
  endfunction

  function int pending();
    return expected_pixels.size();
  endfunction

  task report(string what);
    mismatches++;
    if (mismatches <= 100) $display("%0t mismatch: %s", $time, what);
  endtask

  task check_pixel(amo_out_t got);
    amo_out_t want;
    if (expected_pixels.size() == 0) begin
      report($sformatf("pixel result with none pending: %h", got));
      return;
    end
    want = expected_pixels.pop_front();
    if (got.out_red !== want.out_red)
      report($sformatf("red %h, want %h", got.out_red, want.out_red));
    if (got.out_green !== want.out_green)
      report($sformatf("green %h, want %h", got.out_green, want.out_green));
    if (got.out_blue !== want.out_blue)
      report($sformatf("blue %h, want %h", got.out_blue, want.out_blue));
    if (got.hole_too_big !== want.hole_too_big)
      report($sformatf("hole_too_big %b, want %b", got.hole_too_big, want.hole_too_big));
  endtask
endclass

module annulus_mask_overlay_tb;

  localparam int          ClkPeriod     = 10;
  localparam int          SettleCycles  = 8;
  localparam int          HoldCycles    = 80;
  localparam int          WatchdogLimit = 1000;
  localparam int unsigned NumRegs       = REG_KEEP + 1;
  localparam logic [1:0]  CmdUnused     = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  amo_in_t            in_item;
  logic               out_valid;
  logic               out_stall;
  amo_out_t           out_item;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_data;

  annulus_predictor predictor;
  int               idle_cycles = 0;
  bit               calm = 1'b0;
  bit               hold_off_req = 1'b0;
  int               cur_w = 1, cur_h = 1, cur_outer = 1600;
  int               aim_x [$];
  int               aim_y [$];

  annulus_mask_overlay dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) predictor.check_pixel(out_item);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 10);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic int clamp16(int v);
    if (v < 0) return 0;
    if (v > 65535) return 65535;
    return v;
  endfunction

  function automatic amo_in_t make_item(logic [1:0] cmd);
    amo_in_t it;
    it.cmd       = cmd;
    it.center_x  = CoordW'($urandom);
    it.center_y  = CoordW'($urandom);
    it.pixel_x   = ChanW'($urandom);
    it.pixel_y   = ChanW'($urandom);
    it.src_red   = ChanW'($urandom);
    it.src_green = ChanW'($urandom);
    it.src_blue  = ChanW'($urandom);
    return it;
  endfunction

  function automatic amo_in_t pixel_at(int x, int y, int r, int g, int b);
    amo_in_t it;
    it           = make_item(CMD_PIXEL);
    it.pixel_x   = ChanW'(x);
    it.pixel_y   = ChanW'(y);
    it.src_red   = ChanW'(r);
    it.src_green = ChanW'(g);
    it.src_blue  = ChanW'(b);
    return it;
  endfunction

  function automatic amo_in_t center_at(int x, int y);
    amo_in_t it;
    it          = make_item(CMD_APPEND);
    it.center_x = CoordW'(x);
    it.center_y = CoordW'(y);
    return it;
  endfunction

  // pixel in a square around some center the block should hold, out to the outer radius plus two pixels, at most 3000
  function automatic amo_in_t aimed_pixel();
    amo_in_t it;
    int      cx, cy, reach, sel;
    it = make_item(CMD_PIXEL);
    if (aim_x.size() == 0) begin
      cx = cur_w / 2;
      cy = cur_h / 2;
    end else begin
      sel = $urandom_range(0, aim_x.size() - 1);
      cx  = aim_x[sel];
      cy  = aim_y[sel];
    end
    reach = (cur_outer >> FracBitsDef) + 2;
    if (reach > 3000) reach = 3000;
    it.pixel_x = ChanW'(clamp16(cx + int'($urandom_range(0, 2 * reach)) - reach));
    it.pixel_y = ChanW'(clamp16(cy + int'($urandom_range(0, 2 * reach)) - reach));
    return it;
  endfunction

  task automatic send_item(input amo_in_t it);
    int gap;
    if (!calm && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predictor.take_item(it);
    case (it.cmd)
      CMD_CLEAR: begin
        aim_x.delete();
        aim_y.delete();
      end
      CMD_APPEND: begin
        if (aim_x.size() < MaxCentersDef) begin
          aim_x = {aim_x, int'(it.center_x >> FracBitsDef)};
          aim_y = {aim_y, int'(it.center_y >> FracBitsDef)};
        end
      end
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (predictor.pending() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic program_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    predictor.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic load_config(input int w, input int h, input int fill, input int outer,
                             input int inner, input int keep);
    cur_w     = w;
    cur_h     = h;
    cur_outer = outer;
    program_reg(REG_WIDTH,  {4'($urandom), 16'(w)});
    program_reg(REG_HEIGHT, {4'($urandom), 16'(h)});
    program_reg(REG_FILL,   {4'($urandom), 16'(fill)});
    program_reg(REG_OUTER,  CfgW'(outer));
    program_reg(REG_INNER,  CfgW'(inner));
    program_reg(REG_KEEP,   {19'($urandom), 1'(keep)});
    program_reg(CfgIdxW'($urandom_range(NumRegs, (1 << CfgIdxW) - 1)), CfgW'($urandom));
    cfg_we <= 1'b0;
    repeat (3) @(negedge clk);
  endtask

  task automatic load_random_config();
    int outer, inner;
    outer = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 20'hFFFFF))
                                        : int'($urandom_range(0, 1600));
    inner = ($urandom_range(0, 3) != 0) ? int'($urandom_range(0, outer))
                                        : int'($urandom_range(0, 20'hFFFFF));
    load_config($urandom_range(1, 65535), $urandom_range(1, 65535),
                $urandom_range(0, 65535), outer, inner, $urandom_range(0, 1));
  endtask

  // mostly whole frames: clear, a few centers (some past the table limit),
  // then pixels around them; the rest is loose noise
  task automatic run_phase(input int n_items, input bit hold, input bit pause);
    int      sent;
    int      k;
    amo_in_t it;
    sent = 0;
    while (sent < n_items) begin
      if (hold && sent >= 10) begin
        hold_off_req = 1'b1;
        hold = 1'b0;
      end
      if (pause && sent >= n_items / 2) begin
        drain();
        pause = 1'b0;
      end
      if ($urandom_range(0, 99) < 85) begin
        send_item(make_item(CMD_CLEAR));
        sent++;
        k = $urandom_range(0, MaxCentersDef + 2);
        repeat (k) begin
          send_item(make_item(CMD_APPEND));
          sent++;
        end
        k = $urandom_range(1, 12);
        repeat (k) begin
          if ($urandom_range(0, 29) == 0) send_item(make_item(CmdUnused));
          send_item(($urandom_range(0, 4) == 0) ? make_item(CMD_PIXEL) : aimed_pixel());
          sent++;
        end
      end else begin
        it = make_item(2'($urandom));
        send_item(it);
        if (it.cmd != CmdUnused) sent++;
      end
    end
  endtask

  task automatic run_directed();
    amo_in_t it;
    send_item(pixel_at(0, 0, 0, 0, 0));
    send_item(pixel_at(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    it = '1;
    send_item(it);
    send_item(make_item(CMD_CLEAR));
    send_item(center_at(0, 0));
    send_item(center_at(20'hFFFFF, 20'hFFFFF));
    send_item(center_at(20'h12340, 20'h0ABC0));
    repeat (MaxCentersDef - 3) send_item(make_item(CMD_APPEND));
    // table is full, this one must be dropped
    send_item(center_at(20'h80000, 20'h80000));
    send_item(pixel_at(0, 0, 16'h1111, 16'h2222, 16'h3333));
    send_item(pixel_at(16'hFFFF, 16'hFFFF, 0, 0, 0));
    send_item(pixel_at(16'h8000, 16'h8000, 16'hAAAA, 16'h5555, 16'hFFFF));
    send_item(pixel_at(16'h1234, 16'h0ABC, 0, 16'hFFFF, 0));
    send_item(make_item(CMD_CLEAR));
    send_item(pixel_at(0, 1, 16'h0F0F, 16'hF0F0, 16'h00FF));
    send_item(pixel_at(16'hFFFF, 0, 16'h0F0F, 16'hF0F0, 16'h00FF));
  endtask

  initial begin
    predictor = new();
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= '0;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    drain();

    // exact-center hits only
    load_config(2, 2, 0, 0, 0, 0);
    run_phase(80, 1'b0, 1'b0);
    drain();
    load_config(65535, 65535, 65535, 20'hFFFFF, 0, 1);
    run_phase(80, 1'b1, 1'b0);
    drain();
    load_config(1, 65535, 12345, 20'hFFFFF, 20'hFFFFF, 0);
    run_phase(80, 1'b0, 1'b1);
    drain();
    // hole larger than disk
    load_config(640, 480, $urandom_range(0, 65535), 100, 20'hFFFFF, 1);
    run_phase(60, 1'b0, 1'b0);
    drain();
    // thin ring
    load_config(320, 240, $urandom_range(0, 65535), 320, 320, 0);
    run_phase(60, 1'b0, 1'b0);
    drain();

    for (int p = 0; p < 8; p++) begin
      calm = (p >= 6);
      load_random_config();
      run_phase(85, 1'b0, 1'b0);
      drain();
    end

    if (predictor.pending() != 0) predictor.report("pixel results still pending at end");
    if (predictor.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
